// ----- design/bps_pkg.sv -----
// bps_pkg: payload types, register indexes and constants of the Blinn-Phong
// shader unit. Holds the elaboration-time root functions used by the exp2 stages.
// No dependencies.
`timescale 1ns / 1ps

package bps_pkg;

  // one shading request
  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] ray_dir_x;
    logic signed [15:0] ray_dir_y;
    logic signed [15:0] ray_dir_z;
    logic signed [15:0] light_dir_x;
    logic signed [15:0] light_dir_y;
    logic signed [15:0] light_dir_z;
    logic [15:0]        light_red;
    logic [15:0]        light_green;
    logic [15:0]        light_blue;
  } in_item_t;

  // one shaded color
  typedef struct packed {
    logic [15:0] color_red;
    logic [15:0] color_green;
    logic [15:0] color_blue;
  } out_item_t;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_DIFFUSE_RED    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DIFFUSE_GREEN  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DIFFUSE_BLUE   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPECULAR_RED   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPECULAR_GREEN = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SPECULAR_BLUE  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SHININESS      = 3'd6;

  // saturation level of the power term, Q.15
  localparam logic [20:0] POW_CAP = 21'h1FFFFF;
  // power term for a zero exponent (1.0 in Q.15)
  localparam logic [20:0] POW_ONE = 21'd32768;

  // integer square root, only evaluated at elaboration
  function automatic logic [31:0] isqrt64(input logic [63:0] x);
    logic [65:0] rem;
    logic [65:0] trial;
    logic [31:0] root;
    rem  = '0;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      rem   = {rem[63:0], x[2*i +: 2]};
      trial = {32'd0, root, 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[30:0], 1'b1};
      end else begin
        root = {root[30:0], 1'b0};
      end
    end
    return root;
  endfunction

  // 2^(2^(idx-16)) in Q1.30, built as a chain of square roots of 2
  function automatic logic [30:0] exp_root(input int idx);
    logic [63:0] r;
    r = 64'd1 << 30;
    for (int j = 15; j >= idx; j--) begin
      r = {32'd0, isqrt64((r == (64'd1 << 30)) ? (64'd1 << 61) : (r << 30))};
    end
    return r[30:0];
  endfunction

endpackage

// ----- design/blinn_phong_shader_unit.sv -----
// Blinn-Phong shader unit: one fragment per item, fully pipelined.
// Throughput: one item per cycle; the 127 register stages (two 25-step square
// roots, two 15-step dividers, 16 log2 squarings and 16 exp2 multiplies)
// advance together and hold while the output stalls.
// Reset clears the stage valid bits and the seven material registers.
`timescale 1ns / 1ps

module blinn_phong_shader_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bps_pkg::in_item_t           in_item_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bps_pkg::out_item_t          out_item_o,
  // register write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bps_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                 cfg_data_i
);
  import bps_pkg::*;

  // stage map
  localparam int NS       = 127;
  localparam int PhLen    = 43;   // squares, 25 root steps, prep, 15 div steps, finish
  localparam int StDotH   = 87;
  localparam int StLead   = 88;
  localparam int StLog    = 89;
  localparam int StYMul   = 105;
  localparam int StYSplit = 106;
  localparam int StExp    = 107;
  localparam int StPow    = 123;
  localparam int StCh0    = 124;
  localparam int StCh1    = 125;
  localparam int StCh2    = 126;

  typedef struct packed {
    logic [2:0][15:0] nrm;     // normal, signed Q2.14
    logic [2:0][15:0] lgt;     // light direction, signed Q2.14
    logic [2:0][15:0] lcol;    // light color
    logic [2:0][16:0] vec;     // vector under normalization, signed
    logic [2:0][15:0] mag;
    logic [33:0]      len2;
    logic [25:0]      srem;
    logic [24:0]      root;
    logic [2:0][25:0] drem;
    logic [2:0][14:0] quo;
    logic [2:0][15:0] half;    // half vector, signed Q2.14
    logic             nil;     // zero-length vector
    logic [18:0]      ndl;
    logic [17:0]      ndh;
    logic [4:0]       lead;
    logic [30:0]      mlog;
    logic [15:0]      lgfrac;
    logic signed [37:0] yprod;
    logic [13:0]      ip;      // signed integer part of the exponent
    logic [15:0]      fr;
    logic [30:0]      mant;
    logic [20:0]      pw;
    logic [2:0][31:0] dl;
    logic [2:0][31:0] sl;
    logic [2:0][50:0] dterm;
    logic [2:0][52:0] sterm;
    logic [2:0][15:0] col;
  } item_t;

  item_t           pipe_d [NS];
  item_t           pipe_q [NS];
  logic [NS-1:0]   vld_q;
  logic            adv;

  logic [2:0][15:0] dif_q;
  logic [2:0][15:0] spc_q;
  logic [15:0]      shin_q;

  // signed dot product of two Q2.14 vectors, result in Q.28
  function automatic logic signed [32:0] dot3(input logic [2:0][15:0] a,
                                              input logic [2:0][15:0] b);
    logic signed [31:0] p0;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    p0 = $signed(a[0]) * $signed(b[0]);
    p1 = $signed(a[1]) * $signed(b[1]);
    p2 = $signed(a[2]) * $signed(b[2]);
    return $signed({p0[31], p0}) + $signed({p1[31], p1}) + $signed({p2[31], p2});
  endfunction

  // material registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dif_q  <= '0;
      spc_q  <= '0;
      shin_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DIFFUSE_RED:    dif_q[0] <= cfg_data_i;
        CFG_DIFFUSE_GREEN:  dif_q[1] <= cfg_data_i;
        CFG_DIFFUSE_BLUE:   dif_q[2] <= cfg_data_i;
        CFG_SPECULAR_RED:   spc_q[0] <= cfg_data_i;
        CFG_SPECULAR_GREEN: spc_q[1] <= cfg_data_i;
        CFG_SPECULAR_BLUE:  spc_q[2] <= cfg_data_i;
        CFG_SHININESS:      shin_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advance: everything moves unless a finished item is held
  assign adv         = !vld_q[NS-1] || !out_stall_i;
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[NS-1];

  // capture: negate the ray and take magnitudes
  logic [2:0][15:0] cap_ray;
  always_comb begin
    logic signed [16:0] nv;
    logic [16:0]        ab;
    cap_ray = {in_item_i.ray_dir_z, in_item_i.ray_dir_y, in_item_i.ray_dir_x};
    pipe_d[0]      = '0;
    pipe_d[0].nrm  = {in_item_i.normal_z, in_item_i.normal_y, in_item_i.normal_x};
    pipe_d[0].lgt  = {in_item_i.light_dir_z, in_item_i.light_dir_y, in_item_i.light_dir_x};
    pipe_d[0].lcol = {in_item_i.light_blue, in_item_i.light_green, in_item_i.light_red};
    for (int c = 0; c < 3; c++) begin
      nv = 17'sd0 - $signed({cap_ray[c][15], cap_ray[c]});
      ab = nv[16] ? 17'(17'sd0 - nv) : 17'(nv);
      pipe_d[0].vec[c] = nv;
      pipe_d[0].mag[c] = ab[15:0];
    end
  end

  // two normalizations: view vector, then half vector
  for (genvar ph = 0; ph < 2; ph++) begin : g_unit
    localparam int Base = 1 + ph * PhLen;

    // squared length; the n.l dot rides along in the first pass
    always_comb begin
      logic signed [32:0] d;
      pipe_d[Base] = pipe_q[Base-1];
      pipe_d[Base].len2 = {2'b0, 32'(pipe_q[Base-1].mag[0] * pipe_q[Base-1].mag[0])}
                        + {2'b0, 32'(pipe_q[Base-1].mag[1] * pipe_q[Base-1].mag[1])}
                        + {2'b0, 32'(pipe_q[Base-1].mag[2] * pipe_q[Base-1].mag[2])};
      pipe_d[Base].srem = '0;
      pipe_d[Base].root = '0;
      d = dot3(pipe_q[Base-1].nrm, pipe_q[Base-1].lgt);
      if (ph == 0) begin
        pipe_d[Base].ndl = (d > 33'sd0) ? d[31:13] : 19'd0;
      end
    end

    // square root of len2 * 2^16, one result bit per stage
    for (genvar j = 0; j < 25; j++) begin : g_sqrt
      localparam int K = Base + 1 + j;
      logic [49:0] xs;
      logic [27:0] rsh;
      logic [27:0] tr;
      always_comb begin
        pipe_d[K] = pipe_q[K-1];
        xs  = {pipe_q[K-1].len2, 16'd0};
        rsh = {pipe_q[K-1].srem, xs[49-2*j -: 2]};
        tr  = {2'b0, pipe_q[K-1].root[23:0], 2'b01};
        if (rsh >= tr) begin
          pipe_d[K].srem = 26'(rsh - tr);
          pipe_d[K].root = {pipe_q[K-1].root[23:0], 1'b1};
        end else begin
          pipe_d[K].srem = rsh[25:0];
          pipe_d[K].root = {pipe_q[K-1].root[23:0], 1'b0};
        end
      end
    end

    // divider setup: numerator is mag * 2^22 + root / 2
    always_comb begin
      logic [38:0] num;
      pipe_d[Base+26] = pipe_q[Base+25];
      pipe_d[Base+26].nil = (pipe_q[Base+25].len2 == 34'd0);
      for (int c = 0; c < 3; c++) begin
        num = {1'b0, pipe_q[Base+25].mag[c], 22'd0}
            + {15'd0, pipe_q[Base+25].root[24:1]};
        pipe_d[Base+26].drem[c] = {2'b0, num[38:15]};
        pipe_d[Base+26].quo[c]  = '0;
      end
    end

    // restoring division, one quotient bit per stage
    for (genvar i = 0; i < 15; i++) begin : g_div
      localparam int K = Base + 27 + i;
      localparam int B = 14 - i;
      logic [2:0][25:0] rs;
      logic [2:0]       ge;
      always_comb begin
        pipe_d[K] = pipe_q[K-1];
        for (int c = 0; c < 3; c++) begin
          rs[c] = {pipe_q[K-1].drem[c][24:0], pipe_q[K-1].root[B+1]};
          ge[c] = (rs[c] >= {1'b0, pipe_q[K-1].root});
          pipe_d[K].drem[c] = ge[c] ? 26'(rs[c] - {1'b0, pipe_q[K-1].root}) : rs[c];
          pipe_d[K].quo[c]  = {pipe_q[K-1].quo[c][13:0], ge[c]};
        end
      end
    end

    // signed unit vector; first pass also forms v + l
    always_comb begin
      logic [15:0]        q;
      logic [15:0]        u;
      logic signed [16:0] hs;
      logic [16:0]        ab;
      pipe_d[Base+42] = pipe_q[Base+41];
      for (int c = 0; c < 3; c++) begin
        q = {1'b0, pipe_q[Base+41].quo[c]};
        u = pipe_q[Base+41].vec[c][16] ? 16'(16'd0 - q) : q;
        if (ph == 0) begin
          if (pipe_q[Base+41].nil) begin
            u = '0;
          end
          hs = $signed({u[15], u}) + $signed({pipe_q[Base+41].lgt[c][15],
                                              pipe_q[Base+41].lgt[c]});
          ab = hs[16] ? 17'(17'sd0 - hs) : 17'(hs);
          pipe_d[Base+42].vec[c] = hs;
          pipe_d[Base+42].mag[c] = ab[15:0];
        end else begin
          pipe_d[Base+42].half[c] = u;
        end
      end
    end
  end

  // n.h clamped to Q.15
  always_comb begin
    logic signed [32:0] d;
    pipe_d[StDotH] = pipe_q[StDotH-1];
    d = dot3(pipe_q[StDotH-1].nrm, pipe_q[StDotH-1].half);
    pipe_d[StDotH].ndh = (d > 33'sd0) ? d[30:13] : 18'd0;
  end

  // leading one and normalization to Q1.30
  always_comb begin
    logic [4:0] k;
    k = '0;
    pipe_d[StLead] = pipe_q[StLead-1];
    for (int b = 0; b < 18; b++) begin
      if (pipe_q[StLead-1].ndh[b]) begin
        k = 5'(b);
      end
    end
    pipe_d[StLead].lead   = k;
    pipe_d[StLead].mlog   = 31'({13'd0, pipe_q[StLead-1].ndh} << (5'd30 - k));
    pipe_d[StLead].lgfrac = '0;
  end

  // log2 fraction by repeated squaring, one bit per stage
  for (genvar t = 0; t < 16; t++) begin : g_log
    localparam int K = StLog + t;
    logic [61:0] sq;
    always_comb begin
      pipe_d[K] = pipe_q[K-1];
      sq = {31'd0, pipe_q[K-1].mlog} * {31'd0, pipe_q[K-1].mlog};
      if (sq[61]) begin
        pipe_d[K].lgfrac = {pipe_q[K-1].lgfrac[14:0], 1'b1};
        pipe_d[K].mlog   = sq[61:31];
      end else begin
        pipe_d[K].lgfrac = {pipe_q[K-1].lgfrac[14:0], 1'b0};
        pipe_d[K].mlog   = sq[60:30];
      end
    end
  end

  // exponent product log2(x) * shininess
  always_comb begin
    logic [20:0] lgf;
    pipe_d[StYMul] = pipe_q[StYMul-1];
    lgf = {5'(pipe_q[StYMul-1].lead - 5'd15), pipe_q[StYMul-1].lgfrac};
    pipe_d[StYMul].yprod = $signed(lgf) * $signed({1'b0, shin_q});
  end

  // scale to Q.16 toward zero, split into integer and fraction
  always_comb begin
    logic signed [37:0] tmp;
    pipe_d[StYSplit] = pipe_q[StYSplit-1];
    tmp = pipe_q[StYSplit-1].yprod[37] ? 38'(pipe_q[StYSplit-1].yprod + 38'sd255)
                                       : pipe_q[StYSplit-1].yprod;
    pipe_d[StYSplit].ip   = tmp[37:24];
    pipe_d[StYSplit].fr   = tmp[23:8];
    pipe_d[StYSplit].mant = 31'd1 << 30;
  end

  // exp2 of the fraction, one root factor per stage
  for (genvar t = 0; t < 16; t++) begin : g_exp
    localparam int K = StExp + t;
    localparam int I = 15 - t;
    localparam logic [30:0] Root = exp_root(I);
    logic [62:0] pr;
    always_comb begin
      pipe_d[K] = pipe_q[K-1];
      pr = {32'd0, pipe_q[K-1].mant} * {32'd0, Root} + (63'd1 << 29);
      if (pipe_q[K-1].fr[I]) begin
        pipe_d[K].mant = pr[60:30];
      end
    end
  end

  // power term: special cases, rounding shift, saturation
  always_comb begin
    logic signed [14:0] sh;
    logic [14:0]        s;
    logic [4:0]         s5;
    logic [31:0]        sm;
    logic [31:0]        r;
    pipe_d[StPow] = pipe_q[StPow-1];
    sh = $signed({pipe_q[StPow-1].ip[13], pipe_q[StPow-1].ip}) - 15'sd15;
    s  = 15'(15'sd0 - sh);
    s5 = s[4:0];
    sm = {1'b0, pipe_q[StPow-1].mant} + (32'd1 << (s5 - 5'd1));
    r  = sm >> s5;
    if (pipe_q[StPow-1].nil) begin
      pipe_d[StPow].pw = '0;
    end else if (shin_q == 16'd0) begin
      pipe_d[StPow].pw = POW_ONE;
    end else if (pipe_q[StPow-1].ndh == 18'd0) begin
      pipe_d[StPow].pw = '0;
    end else if (!sh[14]) begin
      pipe_d[StPow].pw = POW_CAP;
    end else if (s >= 15'd32) begin
      pipe_d[StPow].pw = '0;
    end else begin
      pipe_d[StPow].pw = (r > {11'd0, POW_CAP}) ? POW_CAP : r[20:0];
    end
  end

  // material times light color
  always_comb begin
    pipe_d[StCh0] = pipe_q[StCh0-1];
    for (int c = 0; c < 3; c++) begin
      pipe_d[StCh0].dl[c] = {16'd0, dif_q[c]} * {16'd0, pipe_q[StCh0-1].lcol[c]};
      pipe_d[StCh0].sl[c] = {16'd0, spc_q[c]} * {16'd0, pipe_q[StCh0-1].lcol[c]};
    end
  end

  // diffuse and specular terms
  always_comb begin
    pipe_d[StCh1] = pipe_q[StCh1-1];
    for (int c = 0; c < 3; c++) begin
      pipe_d[StCh1].dterm[c] = {19'd0, pipe_q[StCh1-1].dl[c]}
                             * {32'd0, pipe_q[StCh1-1].ndl};
      pipe_d[StCh1].sterm[c] = {21'd0, pipe_q[StCh1-1].sl[c]}
                             * {32'd0, pipe_q[StCh1-1].pw};
    end
  end

  // sum, round to Q1.15, saturate
  always_comb begin
    logic [53:0] sum;
    pipe_d[StCh2] = pipe_q[StCh2-1];
    for (int c = 0; c < 3; c++) begin
      sum = {3'b0, pipe_q[StCh2-1].dterm[c]} + {1'b0, pipe_q[StCh2-1].sterm[c]}
          + (54'd1 << 29);
      pipe_d[StCh2].col[c] = (sum[53:30] > 24'd65535) ? 16'hFFFF : sum[45:30];
    end
  end

  // stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NS; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  assign out_item_o.color_red   = pipe_q[NS-1].col[0];
  assign out_item_o.color_green = pipe_q[NS-1].col[1];
  assign out_item_o.color_blue  = pipe_q[NS-1].col[2];

`ifndef SYNTHESIS
  // input is held back only by a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // a frozen pipeline keeps its valid bits
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("valid bits moved during a stall");

  // an accepted item enters the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted item lost at entry");

  // no item appears from nothing
  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_valid_i && adv) |=> !vld_q[0])
    else $error("first stage valid without an accepted item");
`endif

endmodule

// ----- tb/blinn_phong_shader_unit_tb.sv -----
// blinn_phong_shader_unit_tb: self-checking bench for the Blinn-Phong shader unit.
// Predicts each shaded color in fixed point and compares it with the result channel.
// Depends on bps_pkg and blinn_phong_shader_unit.
`timescale 1ns / 1ps

module blinn_phong_shader_unit_tb;
  import bps_pkg::*;

  typedef longint vec3_t [3];

  localparam int PipeDepth   = 140;
  localparam int IdleLimit   = 3000;
  localparam int LongHold    = 400;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 3'd7;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  in_item_t           in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_item_t          out_item_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [15:0]        cfg_data_i;

  blinn_phong_shader_unit DUT (.*);

  // shadow copy of the material registers
  logic [15:0] mat_dif_r, mat_dif_g, mat_dif_b;
  logic [15:0] mat_spc_r, mat_spc_g, mat_spc_b;
  logic [15:0] mat_shine;

  out_item_t   color_q[$];
  int          err_cnt;
  int          idle_cycles;
  int          hold_cnt;
  int          stall_mode;
  bit          gaps_on;
  int          burst_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // unit vector in Q2.14, zero vector gives zero and returns 0
  function automatic bit make_unit(input vec3_t a, output vec3_t o);
    logic [63:0] mag[3];
    logic [63:0] len2, s, q;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (a[i] < 0) ? -a[i] : a[i];
      len2 = len2 + mag[i] * mag[i];
    end
    if (len2 == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return 1'b0;
    end
    s = int_sqrt(len2 << 16);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 22) + (s >> 1)) / s;
      o[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  // clamped dot product in Q.15
  function automatic logic [63:0] clamp_dot(input vec3_t a, input vec3_t b);
    longint d;
    d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    return (d > 0) ? ($unsigned(d) >> 13) : 64'd0;
  endfunction

  // x^e with x in Q.15 and e in Q8.8, saturated
  function automatic logic [63:0] spec_power(input logic [63:0] x, input logic [63:0] e);
    logic [63:0] m, mant, r;
    longint k, lg, y, ip, fr, sh;
    if (e == 0) return 64'd32768;
    if (x == 0) return 64'd0;
    k = 0;
    while ((x >> (k + 1)) != 0) k++;
    m = x << (30 - k);
    lg = 0;
    // log2 fraction bits by repeated squaring
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      lg = lg << 1;
      if (m >= (64'd1 << 31)) begin
        lg = lg | 1;
        m = m >> 1;
      end
    end
    lg = lg + (k - 15) * 65536;
    y = (lg * longint'(e)) / 256;
    ip = y / 65536;
    fr = y % 65536;
    if (fr < 0) begin
      fr = fr + 65536;
      ip = ip - 1;
    end
    // exp2 of the fraction from a chain of square roots of 2
    mant = 64'd1 << 30;
    r = mant;
    for (int i = 15; i >= 0; i--) begin
      r = int_sqrt((r == (64'd1 << 30)) ? (64'd2 << 60) : (r << 30));
      if (((fr >> i) & 1) != 0) mant = (mant * r + (64'd1 << 29)) >> 30;
    end
    sh = ip - 15;
    if (sh >= 0) begin
      if (sh > 20) return 64'(POW_CAP);
      mant = mant << sh;
      return (mant > 64'(POW_CAP)) ? 64'(POW_CAP) : mant;
    end
    sh = -sh;
    if (sh >= 63) return 64'd0;
    mant = (mant + (64'd1 << (sh - 1))) >> sh;
    return (mant > 64'(POW_CAP)) ? 64'(POW_CAP) : mant;
  endfunction

  function automatic logic [15:0] shade_channel(input logic [63:0] dif, input logic [63:0] spc,
                                                input logic [63:0] lc, input logic [63:0] ndl,
                                                input logic [63:0] p);
    logic [63:0] sum, c;
    sum = dif * lc * ndl + spc * lc * p;
    c = (sum + (64'd1 << 29)) >> 30;
    return (c > 65535) ? 16'hFFFF : c[15:0];
  endfunction

  function automatic out_item_t shade(input in_item_t it);
    vec3_t n, l, nr, v, hs, h;
    logic [63:0] ndl, p;
    out_item_t res;
    n  = '{longint'(it.normal_x), longint'(it.normal_y), longint'(it.normal_z)};
    nr = '{-longint'(it.ray_dir_x), -longint'(it.ray_dir_y), -longint'(it.ray_dir_z)};
    l  = '{longint'(it.light_dir_x), longint'(it.light_dir_y), longint'(it.light_dir_z)};
    void'(make_unit(nr, v));
    for (int i = 0; i < 3; i++) hs[i] = v[i] + l[i];
    ndl = clamp_dot(n, l);
    p = 0;
    if (make_unit(hs, h)) p = spec_power(clamp_dot(n, h), 64'(mat_shine));
    res.color_red   = shade_channel(64'(mat_dif_r), 64'(mat_spc_r), 64'(it.light_red), ndl, p);
    res.color_green = shade_channel(64'(mat_dif_g), 64'(mat_spc_g), 64'(it.light_green), ndl, p);
    res.color_blue  = shade_channel(64'(mat_dif_b), 64'(mat_spc_b), 64'(it.light_blue), ndl, p);
    return res;
  endfunction

  // ---------------------------------------------------------------- result checking
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (color_q.size() == 0) begin
        $error("color result with no request pending");
        err_cnt++;
      end else begin
        want = color_q.pop_front();
        if (out_item_o.color_red !== want.color_red) begin
          $error("color_red expected %0d actual %0d", want.color_red, out_item_o.color_red);
          err_cnt++;
        end
        if (out_item_o.color_green !== want.color_green) begin
          $error("color_green expected %0d actual %0d", want.color_green,
                 out_item_o.color_green);
          err_cnt++;
        end
        if (out_item_o.color_blue !== want.color_blue) begin
          $error("color_blue expected %0d actual %0d", want.color_blue, out_item_o.color_blue);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("blinn_phong_shader_unit_tb failed");
        $finish;
      end
    end
  end

  // result side stall pattern, with an optional long hold
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cnt > 0) begin
        out_stall_i <= 1'b1;
        hold_cnt--;
      end else begin
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 9) < 6);
        endcase
        if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  // offer one request and hold it until accepted
  task automatic send_request(input in_item_t it);
    int gap;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    color_q.push_back(shade(it));
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(1, 8);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst_left = $urandom_range(0, 30);
      end
    end
  endtask

  // write one register, leaves valid high for a following write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_DIFFUSE_RED:    mat_dif_r = val;
      CFG_DIFFUSE_GREEN:  mat_dif_g = val;
      CFG_DIFFUSE_BLUE:   mat_dif_b = val;
      CFG_SPECULAR_RED:   mat_spc_r = val;
      CFG_SPECULAR_GREEN: mat_spc_g = val;
      CFG_SPECULAR_BLUE:  mat_spc_b = val;
      CFG_SHININESS:      mat_shine = val;
      default: ;
    endcase
  endtask

  // drain the pipeline before touching the material
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (color_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth) @(posedge clk_i);
  endtask

  task automatic set_material(input logic [15:0] dr, input logic [15:0] dg,
                              input logic [15:0] db, input logic [15:0] sr,
                              input logic [15:0] sg, input logic [15:0] sb,
                              input logic [15:0] shine);
    wait_drained();
    write_reg(CFG_DIFFUSE_RED, dr);
    write_reg(CFG_DIFFUSE_GREEN, dg);
    write_reg(CFG_DIFFUSE_BLUE, db);
    write_reg(CFG_SPECULAR_RED, sr);
    write_reg(CFG_SPECULAR_GREEN, sg);
    write_reg(CFG_SPECULAR_BLUE, sb);
    write_reg(CFG_SHININESS, shine);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic in_item_t make_item(input vec3_t n, input vec3_t r, input vec3_t l,
                                         input logic [15:0] cr, input logic [15:0] cg,
                                         input logic [15:0] cb);
    in_item_t it;
    it.normal_x = 16'(n[0]);    it.normal_y = 16'(n[1]);    it.normal_z = 16'(n[2]);
    it.ray_dir_x = 16'(r[0]);   it.ray_dir_y = 16'(r[1]);   it.ray_dir_z = 16'(r[2]);
    it.light_dir_x = 16'(l[0]); it.light_dir_y = 16'(l[1]); it.light_dir_z = 16'(l[2]);
    it.light_red = cr;          it.light_green = cg;        it.light_blue = cb;
    return it;
  endfunction

  function automatic vec3_t rand_vec();
    vec3_t a;
    for (int i = 0; i < 3; i++) a[i] = longint'($signed(16'($urandom())));
    return a;
  endfunction

  // random direction normalized to Q2.14, a zero draw becomes +z
  function automatic vec3_t rand_unit();
    vec3_t a, o;
    a = rand_vec();
    if (!make_unit(a, o)) o = '{0, 0, 16384};
    for (int i = 0; i < 3; i++) if (o[i] > 32767) o[i] = 32767;
    return o;
  endfunction

  function automatic in_item_t rand_request();
    vec3_t n, r, l;
    if ($urandom_range(0, 3) != 0) begin
      n = rand_unit();
      l = rand_unit();
      r = rand_vec();
      // ray straight against the normal, so the view vector is the normal
      if ($urandom_range(0, 3) == 0) for (int i = 0; i < 3; i++) r[i] = -n[i];
    end else begin
      n = rand_vec();
      r = rand_vec();
      l = rand_vec();
    end
    return make_item(n, r, l, 16'($urandom()), 16'($urandom()), 16'($urandom()));
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_reset_material();
    repeat (4) send_request(rand_request());
  endtask

  task automatic test_directed();
    vec3_t z, up, dn;
    z  = '{0, 0, 0};
    up = '{0, 0, 16384};
    dn = '{0, 0, -16384};
    set_material(16'hFFFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h4000, 16'h0001, 16'h0000);
    // zero exponent with a zero base still gives one
    send_request(make_item(up, up, dn, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_item(up, dn, up, 16'hFFFF, 16'h0000, 16'h8000));
    set_material(16'h8000, 16'hFFFF, 16'h1234, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h8000);
    // head-on view and light
    send_request(make_item(up, dn, up, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // zero base with nonzero exponent
    send_request(make_item(up, up, dn, 16'hFFFF, 16'h8000, 16'h0001));
    // zero-length ray, half vector is the light
    send_request(make_item(up, z, up, 16'h8000, 16'h8000, 16'h8000));
    // half vector cancels out
    send_request(make_item(up, up, up, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // everything zero
    send_request(make_item(z, z, z, 16'h0000, 16'h0000, 16'h0000));
    // field extremes, non-unit vectors
    send_request(make_item('{32767, 32767, 32767}, '{-32768, -32768, -32768},
                           '{32767, 32767, 32767}, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_item('{-32768, -32768, -32768}, '{32767, 32767, 32767},
                           '{-32768, -32768, -32768}, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_item('{-32768, 32767, 0}, '{32767, -32768, 1},
                           '{-32768, 32767, -1}, 16'h0001, 16'hFFFE, 16'h7FFF));
    set_material(16'h0000, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF);
    // shininess past the nominal range
    send_request(make_item(up, dn, up, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_item('{0, 11585, 11585}, dn, up, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_item('{32767, 0, 32767}, '{-16384, 0, -16384}, '{32767, 0, 32767},
                           16'hFFFF, 16'hFFFF, 16'hFFFF));
    set_material(16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h0001);
    send_request(make_item('{0, 11585, 11585}, '{0, 0, -16384}, '{0, 16384, 0},
                           16'h8000, 16'h8000, 16'h8000));
    // unused register index must not disturb the material
    wait_drained();
    write_reg(CFG_UNUSED, 16'hFFFF);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    send_request(make_item(up, dn, up, 16'h8000, 16'h8000, 16'h8000));
  endtask

  task automatic test_random(input int count, input logic [15:0] shine);
    set_material(16'($urandom()), 16'($urandom()), 16'($urandom()),
                 16'($urandom()), 16'($urandom()), 16'($urandom()), shine);
    for (int i = 0; i < count; i++) send_request(rand_request());
  endtask

  task automatic test_backpressure(input int count);
    set_material(16'h8000, 16'h6000, 16'h2000, 16'hFFFF, 16'h8000, 16'h4000, 16'h2000);
    gaps_on = 1'b0;
    hold_cnt = LongHold;
    for (int i = 0; i < count; i++) send_request(rand_request());
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    mat_dif_r = 0; mat_dif_g = 0; mat_dif_b = 0;
    mat_spc_r = 0; mat_spc_g = 0; mat_spc_b = 0;
    mat_shine = 0;
    err_cnt = 0;
    idle_cycles = 0;
    hold_cnt = 0;
    stall_mode = 0;
    gaps_on = 1'b0;
    burst_left = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_material();
    test_directed();
    gaps_on = 1'b1;
    stall_mode = 1;
    test_random(220, 16'h0A00);
    test_random(220, 16'h8000);
    test_random(200, 16'h0000);
    test_backpressure(200);
    test_random(150, 16'h0080);
    test_random(140, 16'($urandom()));

    wait_drained();
    if (err_cnt == 0) begin
      $display("blinn_phong_shader_unit_tb passed");
    end else begin
      $display("blinn_phong_shader_unit_tb failed");
    end
    $finish;
  end

endmodule
